[src/scan_point_rasterizer_unit_assert.svh]
// Assertion macros shared by the scan point rasterizer modules.
// Needs i_clk and i_rst_n in the scope of every use.
`ifndef SCAN_POINT_RASTERIZER_UNIT_ASSERT_SVH
`define SCAN_POINT_RASTERIZER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define SPR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scan point rasterizer check failed");
// next-cycle implication
`define SPR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scan point rasterizer check failed");
`else
`define SPR_ASSERT_IMP(lbl, ante, cons)
`define SPR_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

[src/spr_pkg.sv]
// Types, constants and the arctangent table of the scan point rasterizer.
// No dependencies.
package spr_pkg;

    localparam int RANGE_W          = 16;
    localparam int IDX_W            = 12;
    localparam int ANG_W            = 16;
    localparam int Q15_W            = 16;
    localparam int MAG_W            = 15;
    localparam int PROD_W           = RANGE_W + MAG_W;
    localparam int CORDIC_W         = 18;
    localparam int CORDIC_ITERS     = 16;
    localparam int CORDIC_GAIN_INIT = 19898;
    localparam int Q15_MAX          = 32767;
    localparam int QUARTER_TURN     = 16384;
    localparam int HALF_TURN        = 32768;
    localparam int MAX_SAMPLES      = 4096;
    localparam int CFG_W            = 16;

    localparam logic [CFG_W-1:0] ANGLE_START_RST = 16'd0;
    localparam logic [CFG_W-1:0] ANGLE_STEP_RST  = 16'd182;
    localparam logic [CFG_W-1:0] RANGE_MIN_RST   = 16'd0;
    localparam logic [CFG_W-1:0] RANGE_CEIL_RST  = 16'd3500;

    typedef enum logic [1:0] {
        REG_ANGLE_START,
        REG_ANGLE_STEP,
        REG_RANGE_MIN,
        REG_RANGE_CEIL
    } t_reg_idx;

    // folded angle handed to the rotator
    typedef struct packed {
        logic                       keep;
        logic [RANGE_W-1:0]         range;
        logic                       neg;
        logic signed [CORDIC_W-1:0] z;
    } t_rot_in;

    typedef struct packed {
        logic                    keep;
        logic [RANGE_W-1:0]      range;
        logic signed [Q15_W-1:0] cos_q;
        logic signed [Q15_W-1:0] sin_q;
    } t_trig;

    // travels beside the magnitudes through scaling and division
    typedef struct packed {
        logic keep;
        logic cos_neg;
        logic sin_neg;
    } t_tag;

    function automatic logic signed [CORDIC_W-1:0] atan_lut(input int unsigned i);
        logic signed [CORDIC_W-1:0] v;
        case (i)
            0:       v = 18'sd8192;
            1:       v = 18'sd4836;
            2:       v = 18'sd2555;
            3:       v = 18'sd1297;
            4:       v = 18'sd651;
            5:       v = 18'sd326;
            6:       v = 18'sd163;
            7:       v = 18'sd81;
            8:       v = 18'sd41;
            9:       v = 18'sd20;
            10:      v = 18'sd10;
            11:      v = 18'sd5;
            12:      v = 18'sd3;
            13:      v = 18'sd1;
            14:      v = 18'sd1;
            default: v = 18'sd0;
        endcase
        return v;
    endfunction

endpackage

[src/spr_front.sv]
// Front end: sample qualification, beam angle and folding into a quarter turn.
// Depends on spr_pkg.
module spr_front import spr_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [RANGE_W-1:0] i_range,
    input  logic [IDX_W-1:0]   i_index,
    input  logic [CFG_W-1:0]   i_angle_start,
    input  logic [CFG_W-1:0]   i_angle_step,
    input  logic [CFG_W-1:0]   i_range_min,
    input  logic [CFG_W-1:0]   i_range_ceil,
    output logic               o_valid,
    input  logic               i_ready,
    output t_rot_in            o_data
);

    logic [1:0]               r_vld;
    logic [1:0]               w_vin;
    logic [1:0]               w_rdy;
    logic                     r_a_keep;
    logic [RANGE_W-1:0]       r_a_range;
    logic [ANG_W-1:0]         r_a_prod;
    t_rot_in                  r_b;
    t_rot_in                  n_b;
    logic                     n_a_keep;
    logic [IDX_W+ANG_W-1:0]   w_prod;
    logic [ANG_W-1:0]         w_ang;
    logic signed [CORDIC_W-1:0] w_z;

    assign w_vin   = (r_vld << 1) | 2'(i_valid);
    assign w_rdy[1] = i_ready || !r_vld[1];
    assign w_rdy[0] = i_ready || !r_vld[1] || !r_vld[0];
    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[1];
    assign o_data  = r_b;

    always_comb begin
        n_a_keep = (i_range > i_range_min) && (i_range < i_range_ceil) &&
                   ({20'd0, i_index} < 32'(MAX_SAMPLES));
        w_prod   = i_index * i_angle_step;
    end

    // wrap to a signed binary angle, then fold the back half onto the front
    always_comb begin
        w_ang     = i_angle_start + r_a_prod;
        w_z       = CORDIC_W'(signed'(w_ang));
        n_b.keep  = r_a_keep;
        n_b.range = r_a_range;
        n_b.neg   = 1'b0;
        n_b.z     = w_z;
        if (w_z > CORDIC_W'(QUARTER_TURN)) begin
            n_b.z   = w_z - CORDIC_W'(HALF_TURN);
            n_b.neg = 1'b1;
        end else if (w_z < -CORDIC_W'(QUARTER_TURN)) begin
            n_b.z   = w_z + CORDIC_W'(HALF_TURN);
            n_b.neg = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= w_vin[0];
            if (w_rdy[1]) r_vld[1] <= w_vin[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_a_keep  <= n_a_keep;
            r_a_range <= i_range;
            r_a_prod  <= w_prod[ANG_W-1:0];
        end
        if (w_rdy[1]) begin
            r_b <= n_b;
        end
    end

endmodule

[src/spr_cordic.sv]
// Rotation-mode CORDIC, one iteration per stage, then clamp and half-turn sign.
// Depends on spr_pkg.
module spr_cordic import spr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_rot_in i_data,
    output logic    o_valid,
    input  logic    i_ready,
    output t_trig   o_data
);

    localparam int NS = CORDIC_ITERS + 1;

    typedef struct packed {
        logic                       keep;
        logic [RANGE_W-1:0]         range;
        logic                       neg;
        logic signed [CORDIC_W-1:0] x;
        logic signed [CORDIC_W-1:0] y;
        logic signed [CORDIC_W-1:0] z;
    } t_crd;

    localparam logic signed [CORDIC_W-1:0] POS_LIM = CORDIC_W'(Q15_MAX);

    logic [NS-1:0] r_vld;
    logic [NS-1:0] w_vin;
    logic [NS-1:0] w_rdy;
    t_crd          r_st  [CORDIC_ITERS];
    t_crd          w_src [CORDIC_ITERS];
    t_crd          n_st  [CORDIC_ITERS];
    t_trig         r_out;
    t_trig         n_out;
    logic signed [CORDIC_W-1:0] w_cx;
    logic signed [CORDIC_W-1:0] w_cy;

    assign w_vin   = (r_vld << 1) | NS'(i_valid);
    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[NS-1];
    assign o_data  = r_out;

    // a stage may load if anything at or after it has room
    always_comb begin
        for (int k = 0; k < NS; k++) begin
            w_rdy[k] = i_ready || (((~r_vld) >> k) != '0);
        end
    end

    always_comb begin
        w_src[0].keep  = i_data.keep;
        w_src[0].range = i_data.range;
        w_src[0].neg   = i_data.neg;
        w_src[0].x     = CORDIC_W'(CORDIC_GAIN_INIT);
        w_src[0].y     = '0;
        w_src[0].z     = i_data.z;
        for (int k = 1; k < CORDIC_ITERS; k++) begin
            w_src[k] = r_st[k-1];
        end
        for (int k = 0; k < CORDIC_ITERS; k++) begin
            n_st[k] = w_src[k];
            if (w_src[k].z >= 0) begin
                n_st[k].x = w_src[k].x - (w_src[k].y >>> k);
                n_st[k].y = w_src[k].y + (w_src[k].x >>> k);
                n_st[k].z = w_src[k].z - atan_lut(k);
            end else begin
                n_st[k].x = w_src[k].x + (w_src[k].y >>> k);
                n_st[k].y = w_src[k].y - (w_src[k].x >>> k);
                n_st[k].z = w_src[k].z + atan_lut(k);
            end
        end
    end

    always_comb begin
        w_cx = r_st[CORDIC_ITERS-1].x;
        w_cy = r_st[CORDIC_ITERS-1].y;
        if (w_cx > POS_LIM)  w_cx = POS_LIM;
        if (w_cx < -POS_LIM) w_cx = -POS_LIM;
        if (w_cy > POS_LIM)  w_cy = POS_LIM;
        if (w_cy < -POS_LIM) w_cy = -POS_LIM;
        if (r_st[CORDIC_ITERS-1].neg) begin
            w_cx = -w_cx;
            w_cy = -w_cy;
        end
        n_out.keep  = r_st[CORDIC_ITERS-1].keep;
        n_out.range = r_st[CORDIC_ITERS-1].range;
        n_out.cos_q = Q15_W'(w_cx);
        n_out.sin_q = Q15_W'(w_cy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < NS; k++) begin
                if (w_rdy[k]) r_vld[k] <= w_vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < CORDIC_ITERS; k++) begin
            if (w_rdy[k]) r_st[k] <= n_st[k];
        end
        if (w_rdy[NS-1]) r_out <= n_out;
    end

endmodule

[src/spr_scale.sv]
// Scaling of range by |cos| and |sin| and by the image size, two stages.
// Depends on spr_pkg.
module spr_scale import spr_pkg::*; #(
    parameter int IMAGE_SIZE = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  t_trig                                   i_data,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output t_tag                                    o_tag,
    output logic [1:0][MAG_W+$clog2(IMAGE_SIZE)-1:0] o_mag
);

    localparam int QW = $clog2(IMAGE_SIZE);
    localparam int MW = MAG_W + QW;
    localparam int PW = PROD_W + QW;

    logic [1:0]              r_vld;
    logic [1:0]              w_vin;
    logic [1:0]              w_rdy;
    t_tag                    r_a_tag;
    t_tag                    r_b_tag;
    t_tag                    n_a_tag;
    logic [1:0][PROD_W-1:0]  r_a_prod;
    logic [1:0][PROD_W-1:0]  n_a_prod;
    logic [1:0][MW-1:0]      r_b_mag;
    logic [1:0][MW-1:0]      n_b_mag;
    logic signed [Q15_W-1:0] w_trig [2];
    logic [MAG_W-1:0]        w_abs  [2];
    logic [PW-1:0]           w_big  [2];

    assign w_vin    = (r_vld << 1) | 2'(i_valid);
    assign w_rdy[1] = i_ready || !r_vld[1];
    assign w_rdy[0] = i_ready || !r_vld[1] || !r_vld[0];
    assign o_ready  = w_rdy[0];
    assign o_valid  = r_vld[1];
    assign o_tag    = r_b_tag;
    assign o_mag    = r_b_mag;

    always_comb begin
        w_trig[0]       = i_data.cos_q;
        w_trig[1]       = i_data.sin_q;
        n_a_tag.keep    = i_data.keep;
        n_a_tag.cos_neg = i_data.cos_q[Q15_W-1];
        n_a_tag.sin_neg = i_data.sin_q[Q15_W-1];
        for (int l = 0; l < 2; l++) begin
            w_abs[l]    = w_trig[l][Q15_W-1] ? MAG_W'(-w_trig[l]) : w_trig[l][MAG_W-1:0];
            n_a_prod[l] = i_data.range * w_abs[l];
        end
    end

    // product times image size, then drop the Q15 fraction and the factor two
    always_comb begin
        for (int l = 0; l < 2; l++) begin
            w_big[l]   = PW'(r_a_prod[l]) * PW'(IMAGE_SIZE);
            n_b_mag[l] = w_big[l][PW-1:16];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_rdy[0]) r_vld[0] <= w_vin[0];
            if (w_rdy[1]) r_vld[1] <= w_vin[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r_a_tag  <= n_a_tag;
            r_a_prod <= n_a_prod;
        end
        if (w_rdy[1]) begin
            r_b_tag <= r_a_tag;
            r_b_mag <= n_b_mag;
        end
    end

endmodule

[src/spr_div.sv]
// Two-lane restoring divider by the range ceiling, one quotient bit per stage.
// Depends on spr_pkg and the assertion macro header.
`include "scan_point_rasterizer_unit_assert.svh"
module spr_div import spr_pkg::*; #(
    parameter int IMAGE_SIZE = 256
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_valid,
    output logic                                    o_ready,
    input  t_tag                                    i_tag,
    input  logic [1:0][MAG_W+$clog2(IMAGE_SIZE)-1:0] i_mag,
    input  logic [CFG_W-1:0]                        i_range_ceil,
    output logic                                    o_valid,
    input  logic                                    i_ready,
    output t_tag                                    o_tag,
    output logic [1:0][$clog2(IMAGE_SIZE)-1:0]      o_quo
);

    localparam int QW = $clog2(IMAGE_SIZE);
    localparam int MW = MAG_W + QW;

    logic [QW-1:0]    r_vld;
    logic [QW-1:0]    w_vin;
    logic [QW-1:0]    w_rdy;
    t_tag             r_tag  [QW];
    t_tag             w_stag [QW];
    logic [CFG_W-1:0] r_rem  [QW][2];
    logic [CFG_W-1:0] w_srem [QW][2];
    logic [CFG_W-1:0] n_rem  [QW][2];
    logic [QW-1:0]    r_m    [QW][2];
    logic [QW-1:0]    w_sm   [QW][2];
    logic [QW-1:0]    r_q    [QW][2];
    logic [QW-1:0]    w_sq   [QW][2];
    logic [QW-1:0]    n_q    [QW][2];
    logic [CFG_W:0]   w_trial[QW][2];
    logic             w_ge   [QW][2];

    assign w_vin   = (r_vld << 1) | QW'(i_valid);
    assign o_ready = w_rdy[0];
    assign o_valid = r_vld[QW-1];
    assign o_tag   = r_tag[QW-1];
    assign o_quo[0] = r_q[QW-1][0];
    assign o_quo[1] = r_q[QW-1][1];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            w_rdy[k] = i_ready || (((~r_vld) >> k) != '0);
        end
    end

    // the quotient of a kept sample is below 2**QW, so the bits above QW
    // start as a partial remainder already below the divisor
    always_comb begin
        w_stag[0] = i_tag;
        for (int l = 0; l < 2; l++) begin
            w_srem[0][l] = CFG_W'(i_mag[l][MW-1:QW]);
            w_sm[0][l]   = i_mag[l][QW-1:0];
            w_sq[0][l]   = '0;
        end
        for (int k = 1; k < QW; k++) begin
            w_stag[k] = r_tag[k-1];
            for (int l = 0; l < 2; l++) begin
                w_srem[k][l] = r_rem[k-1][l];
                w_sm[k][l]   = r_m[k-1][l];
                w_sq[k][l]   = r_q[k-1][l];
            end
        end
        for (int k = 0; k < QW; k++) begin
            for (int l = 0; l < 2; l++) begin
                w_trial[k][l] = {w_srem[k][l], w_sm[k][l][QW-1]};
                w_ge[k][l]    = w_trial[k][l] >= {1'b0, i_range_ceil};
                n_rem[k][l]   = w_ge[k][l] ? CFG_W'(w_trial[k][l] - {1'b0, i_range_ceil})
                                           : w_trial[k][l][CFG_W-1:0];
                n_q[k][l]     = (w_sq[k][l] << 1) | QW'(w_ge[k][l]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < QW; k++) begin
                if (w_rdy[k]) r_vld[k] <= w_vin[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (w_rdy[k]) begin
                r_tag[k] <= w_stag[k];
                for (int l = 0; l < 2; l++) begin
                    r_rem[k][l] <= n_rem[k][l];
                    r_m[k][l]   <= w_sm[k][l] << 1;
                    r_q[k][l]   <= n_q[k][l];
                end
            end
        end
    end

    `SPR_ASSERT_IMP(a_cos_rem_ok, r_vld[QW-1] && r_tag[QW-1].keep, r_rem[QW-1][0] < i_range_ceil)
    `SPR_ASSERT_IMP(a_sin_rem_ok, r_vld[QW-1] && r_tag[QW-1].keep, r_rem[QW-1][1] < i_range_ceil)

endmodule

[src/scan_point_rasterizer_unit.sv]
// Pipeline: 2 front stages, 16 CORDIC iterations plus clamp, 2 scaling stages,
// one divider stage per quotient bit, and the output register.
// Throughput: one sample per cycle while the output is not stalled; a waiting
// result does not block input while any stage holds a bubble. Synchronous
// active-low reset clears all valid bits and loads the register defaults;
// nothing else needs clearing.
`include "scan_point_rasterizer_unit_assert.svh"
module scan_point_rasterizer_unit import spr_pkg::*; #(
    parameter int IMAGE_SIZE = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // APB-style configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // sample stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,  // [15:0] range_mm, [27:16] sample_index
    // pixel stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // [7:0] pixel_row, [15:8] pixel_col
    output logic        m_axis_tuser   // [0] hit
);

    localparam int QW       = $clog2(IMAGE_SIZE);
    localparam int MW       = MAG_W + QW;
    localparam int ROW_BASE = IMAGE_SIZE - 1 - IMAGE_SIZE / 2;
    localparam int COL_BASE = IMAGE_SIZE / 2;

    logic [CFG_W-1:0] r_angle_start;
    logic [CFG_W-1:0] r_angle_step;
    logic [CFG_W-1:0] r_range_min;
    logic [CFG_W-1:0] r_range_ceil;
    logic             w_cfg_wr;
    t_reg_idx         w_reg;

    logic             w_fr_valid, w_fr_ready;
    t_rot_in          w_fr_data;
    logic             w_cr_valid, w_cr_ready;
    t_trig            w_cr_data;
    logic             w_sc_valid, w_sc_ready;
    t_tag             w_sc_tag;
    logic [1:0][MW-1:0] w_sc_mag;
    logic             w_dv_valid, w_dv_ready;
    t_tag             w_dv_tag;
    logic [1:0][QW-1:0] w_dv_quo;

    logic               r_out_vld;
    logic               r_hit;
    logic [QW-1:0]      r_row;
    logic [QW-1:0]      r_col;
    logic [QW-1:0]      n_row;
    logic [QW-1:0]      n_col;
    logic signed [QW+1:0] w_qc;
    logic signed [QW+1:0] w_qs;
    logic signed [QW+1:0] w_row_full;
    logic signed [QW+1:0] w_col_full;

    // configuration
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;
    assign w_reg    = t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle_start <= ANGLE_START_RST;
            r_angle_step  <= ANGLE_STEP_RST;
            r_range_min   <= RANGE_MIN_RST;
            r_range_ceil  <= RANGE_CEIL_RST;
        end else if (w_cfg_wr) begin
            case (w_reg)
                REG_ANGLE_START: r_angle_start <= pwdata[CFG_W-1:0];
                REG_ANGLE_STEP:  r_angle_step  <= pwdata[CFG_W-1:0];
                REG_RANGE_MIN:   r_range_min   <= pwdata[CFG_W-1:0];
                REG_RANGE_CEIL:  r_range_ceil  <= pwdata[CFG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            REG_ANGLE_START: prdata = 32'(r_angle_start);
            REG_ANGLE_STEP:  prdata = 32'(r_angle_step);
            REG_RANGE_MIN:   prdata = 32'(r_range_min);
            REG_RANGE_CEIL:  prdata = 32'(r_range_ceil);
            default:         prdata = '0;
        endcase
    end

    // datapath
    spr_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_range       (s_axis_tdata[15:0]),
        .i_index       (s_axis_tdata[27:16]),
        .i_angle_start (r_angle_start),
        .i_angle_step  (r_angle_step),
        .i_range_min   (r_range_min),
        .i_range_ceil  (r_range_ceil),
        .o_valid       (w_fr_valid),
        .i_ready       (w_fr_ready),
        .o_data        (w_fr_data)
    );

    spr_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_fr_valid),
        .o_ready (w_fr_ready),
        .i_data  (w_fr_data),
        .o_valid (w_cr_valid),
        .i_ready (w_cr_ready),
        .o_data  (w_cr_data)
    );

    spr_scale #(.IMAGE_SIZE(IMAGE_SIZE)) u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_cr_valid),
        .o_ready (w_cr_ready),
        .i_data  (w_cr_data),
        .o_valid (w_sc_valid),
        .i_ready (w_sc_ready),
        .o_tag   (w_sc_tag),
        .o_mag   (w_sc_mag)
    );

    spr_div #(.IMAGE_SIZE(IMAGE_SIZE)) u_div (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_sc_valid),
        .o_ready      (w_sc_ready),
        .i_tag        (w_sc_tag),
        .i_mag        (w_sc_mag),
        .i_range_ceil (r_range_ceil),
        .o_valid      (w_dv_valid),
        .i_ready      (w_dv_ready),
        .o_tag        (w_dv_tag),
        .o_quo        (w_dv_quo)
    );

    // quotients truncate toward zero; a kept point always lands inside the image
    always_comb begin
        w_qc       = signed'({2'b00, w_dv_quo[0]});
        w_qs       = signed'({2'b00, w_dv_quo[1]});
        if (w_dv_tag.cos_neg) w_qc = -w_qc;
        if (w_dv_tag.sin_neg) w_qs = -w_qs;
        w_row_full = (QW+2)'(ROW_BASE) - w_qc;
        w_col_full = (QW+2)'(COL_BASE) + w_qs;
        n_row      = w_dv_tag.keep ? w_row_full[QW-1:0] : '0;
        n_col      = w_dv_tag.keep ? w_col_full[QW-1:0] : '0;
    end

    assign w_dv_ready = !r_out_vld || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_dv_ready) begin
            r_out_vld <= w_dv_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dv_ready) begin
            r_hit <= w_dv_tag.keep;
            r_row <= n_row;
            r_col <= n_col;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tuser  = r_hit;
    assign m_axis_tdata  = {8'(r_col), 8'(r_row)};

    `SPR_ASSERT_IMP(a_stall_only_when_full, !s_axis_tready, m_axis_tvalid)
    `SPR_ASSERT_IMP(a_miss_is_zero, r_out_vld && !r_hit, r_row == '0 && r_col == '0)
    `SPR_ASSERT_IMP(a_hit_in_image, r_out_vld && r_hit, r_row <= QW'(IMAGE_SIZE - 2) && r_col != '0)

endmodule
